FILE: src/spg_pkg.sv
// types and constants shared by the spiral phase pixel generator
package spg_pkg;

    localparam int COORD_W      = 14;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 41;
    localparam int TURN_W       = 34;
    localparam int COORD_SHIFT  = 24;
    localparam int SIZE_W       = 13;
    localparam int NCYC_W       = 16;
    localparam int ADDR_W       = 3;

    localparam logic REG_SIDE_LEN   = 1'b0;
    localparam logic REG_NUM_CYCLES = 1'b1;

    localparam logic [SIZE_W-1:0] SIDE_LEN_RST   = 13'd256;
    localparam logic [NCYC_W-1:0] NUM_CYCLES_RST = 16'd256;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
    } spg_pixel_t;

    typedef struct packed {
        logic [23:0] phase_value;
        logic        inside_aperture;
    } spg_phase_t;

endpackage

FILE: src/spiral_phase_pixel_generator_unit.sv
// spiral phase plate pixel generator: pipelined vortex phase per pixel
//
// pixel channel: one request carries a row and column of the square array.
// phase channel: one request per pixel, in order, with the vortex phase
// (angle fraction of a turn times num_cycles_q8, 16 fraction bits) and the
// flag for pixels strictly inside the inscribed circle; zero phase outside
// the circle and at the exact centre.
// the apb port holds the array side length (byte address 0) and num_cycles_q8
// (byte address 4); write them only while the pipeline is empty.
// from acceptance to the result on the phase port, a pixel passes the
// coordinate, square and compare stages, one stage per cordic iteration
// (30 of them), a rounding stage and the multiply into the output register.
// throughput is one pixel per cycle while the receiver does not stall.
// when the receiver stalls, the output register holds its result and the
// stages behind it keep moving until they fill, so empty slots are closed
// up before pixel_stall rises.
// reset empties every stage and sets the side length and num_cycles_q8 to 256.
module spiral_phase_pixel_generator_unit #(
    parameter int MAX_SIZE        = 4096,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  spg_pkg::spg_pixel_t         pixel,
    output logic                        phase_valid,
    input  logic                        phase_stall,
    output spg_pkg::spg_phase_t         phase,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import spg_pkg::*;

    localparam int NSTG     = CORDIC_STEPS + 5;
    localparam int DROP     = 32 - ANGLE_FRAC_BITS;
    localparam int PSHIFT   = ANGLE_FRAC_BITS - 8;
    localparam int PROD_W   = ANGLE_FRAC_BITS + NCYC_W;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        SIZE_W'((MAX_SIZE > 8191) ? 8191 : MAX_SIZE);

    // configuration registers
    logic [SIZE_W-1:0] side_len_reg, side_len_next;
    logic [NCYC_W-1:0] num_cycles_q8_reg, num_cycles_q8_next;

    assign pready = 1'b1;

    always_comb
    begin
        side_len_next      = side_len_reg;
        num_cycles_q8_next = num_cycles_q8_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_SIDE_LEN:   side_len_next      = pwdata[SIZE_W-1:0];
                REG_NUM_CYCLES: num_cycles_q8_next = pwdata[NCYC_W-1:0];
                default:        side_len_next      = side_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SIDE_LEN:   prdata = {19'd0, side_len_reg};
            REG_NUM_CYCLES: prdata = {16'd0, num_cycles_q8_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_len_reg      <= SIDE_LEN_RST;
            num_cycles_q8_reg <= NUM_CYCLES_RST;
        end
        else
        begin
            side_len_reg      <= side_len_next;
            num_cycles_q8_reg <= num_cycles_q8_next;
        end
    end

    // stage valids and load enables; a stage loads when it or any later
    // stage is empty, or the output is being taken
    logic [NSTG-1:0] vld_reg, vld_next, adv;

    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            adv[i] = !phase_stall ||
                     !(&(vld_reg | NSTG'((64'd1 << i) - 64'd1)));
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (adv[i])
                vld_next[i] = (i == 0) ? pixel_valid : vld_reg[(i == 0) ? 0 : i - 1];
            else
                vld_next[i] = vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign pixel_stall = !adv[0];
    assign phase_valid = vld_reg[NSTG-1];

    // stage a: centred coordinates in half pixels
    logic [SIZE_W-1:0]         size_sat;
    logic signed [COORD_W-1:0] sa_x_reg, sa_y_reg;
    logic [SIZE_W-1:0]         sa_size_reg;

    assign size_sat = (side_len_reg > SIZE_CAP) ? SIZE_CAP : side_len_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sa_x_reg    <= $signed({1'b0, pixel.col, 1'b0}) - $signed({1'b0, size_sat});
            sa_y_reg    <= $signed({1'b0, pixel.row, 1'b0}) - $signed({1'b0, size_sat});
            sa_size_reg <= size_sat;
        end
    end

    // stage b: squares
    logic signed [2*COORD_W-1:0] xsq, ysq;
    logic [2*SIZE_W-1:0]         ssq;
    logic signed [COORD_W-1:0]   sb_x_reg, sb_y_reg;
    logic [2*SIZE_W-1:0]         sb_xx_reg, sb_yy_reg, sb_ss_reg;

    assign xsq = sa_x_reg * sa_x_reg;
    assign ysq = sa_y_reg * sa_y_reg;
    assign ssq = sa_size_reg * sa_size_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sb_x_reg  <= sa_x_reg;
            sb_y_reg  <= sa_y_reg;
            sb_xx_reg <= xsq[2*SIZE_W-1:0];
            sb_yy_reg <= ysq[2*SIZE_W-1:0];
            sb_ss_reg <= ssq;
        end
    end

    // stage c and cordic stages
    logic signed [CORDIC_W-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [TURN_W-1:0]   cz_reg [0:CORDIC_STEPS];
    logic                       cin_reg  [0:CORDIC_STEPS];
    logic                       clive_reg [0:CORDIC_STEPS];
    logic                       cneg_reg [0:CORDIC_STEPS];

    logic                      neg_x, in_circle, centre;
    logic signed [COORD_W-1:0] ax, ay;

    assign neg_x     = sb_x_reg < 0;
    assign ax        = neg_x ? -sb_x_reg : sb_x_reg;
    assign ay        = neg_x ? -sb_y_reg : sb_y_reg;
    assign in_circle = ({1'b0, sb_xx_reg} + {1'b0, sb_yy_reg}) < {1'b0, sb_ss_reg};
    assign centre    = (sb_x_reg == '0) && (sb_y_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            cx_reg[0]    <= CORDIC_W'(ax) <<< COORD_SHIFT;
            cy_reg[0]    <= CORDIC_W'(ay) <<< COORD_SHIFT;
            cz_reg[0]    <= '0;
            cin_reg[0]   <= in_circle;
            clive_reg[0] <= in_circle && !centre;
            cneg_reg[0]  <= neg_x;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        logic signed [CORDIC_W-1:0] xs, ys;
        logic signed [TURN_W-1:0]   at;

        assign xs = cx_reg[k] >>> k;
        assign ys = cy_reg[k] >>> k;
        assign at = $signed({2'b00, ATAN_TURN[k]});

        always_ff @(posedge clk)
        begin
            if (adv[3+k])
            begin
                if (cy_reg[k] >= 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + ys;
                    cy_reg[k+1] <= cy_reg[k] - xs;
                    cz_reg[k+1] <= cz_reg[k] + at;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - ys;
                    cy_reg[k+1] <= cy_reg[k] + xs;
                    cz_reg[k+1] <= cz_reg[k] - at;
                end
                cin_reg[k+1]   <= cin_reg[k];
                clive_reg[k+1] <= clive_reg[k];
                cneg_reg[k+1]  <= cneg_reg[k];
            end
        end
    end

    // rounding stage: add half turn back, wrap, round to angle bits
    logic signed [TURN_W-1:0]     zt;
    logic [32:0]                  zr;
    logic [ANGLE_FRAC_BITS-1:0]   rd_angle_reg;
    logic                         rd_in_reg;

    assign zt = cz_reg[CORDIC_STEPS] +
                (cneg_reg[CORDIC_STEPS] ? (TURN_W'(1) <<< 31) : '0);
    assign zr = {1'b0, zt[31:0]} + (33'd1 << (DROP - 1));

    always_ff @(posedge clk)
    begin
        if (adv[NSTG-2])
        begin
            rd_angle_reg <= clive_reg[CORDIC_STEPS] ? zr[DROP +: ANGLE_FRAC_BITS] : '0;
            rd_in_reg    <= cin_reg[CORDIC_STEPS];
        end
    end

    // output register: scale by cycle count
    logic [PROD_W-1:0] prod;
    spg_phase_t        out_reg;

    assign prod = rd_angle_reg * num_cycles_q8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NSTG-1])
        begin
            out_reg.phase_value     <= prod[PSHIFT +: 24];
            out_reg.inside_aperture <= rd_in_reg;
        end
    end

    assign phase = out_reg;

endmodule
